// File: src/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// shared types and codes for the generational handle allocator
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int IDX_FIELD_W = 10;
  localparam int GEN_FIELD_W = 32;
  localparam int STATUS_W    = 2;

  // request codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                   cmd;
    logic [IDX_FIELD_W-1:0] release_index;
  } in_req_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] index;
    logic [GEN_FIELD_W-1:0] generation;
    logic [STATUS_W-1:0]    status;
  } out_rsp_t;

endpackage

// File: src/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// allocates and releases handles made of an index and a generation, with a
// lifo free stack of released indexes and a per-index generation store
// ----------------------------------------------------------------------------
//
// channel   ports                         transfer when
// -------   ---------------------------   -----------------------------
// request   start, busy, in_req           start high and busy low
// result    out_valid, out_rsp            every cycle out_valid is high
//
// one request per cycle, sustained; the result is registered after the request
// transfer through stack read, then generation read, then update
// the free stack read and the generation store read are the two memory
// steps on the path from request to result
// rst_n is synchronous and active low; busy is high while reset is applied
// neither memory is cleared: free count and fresh index track what is valid
// the receiver cannot stall, so results leave the pipe unconditionally
//
module generational_handle_allocator #(
  parameter int ENTRIES  = 1024,
  parameter int GEN_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gha_pkg::in_req_t  in_req,
  output logic              out_valid,
  output gha_pkg::out_rsp_t out_rsp
);
  import gha_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [GEN_BITS-1:0] GEN_MAX = {GEN_BITS{1'b1}};

  // what each request turns into once the counters are looked at
  typedef enum logic [2:0] {
    K_POP,
    K_FRESH,
    K_FULL,
    K_REL,
    K_REL_OOB
  } kind_t;

  logic accept;

  // counters
  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] nf_r, nf_nxt;

  // free stack
  logic [IDX_FIELD_W-1:0] stack_mem [ENTRIES];
  logic [IDX_FIELD_W-1:0] stack_q_r;
  logic                   push;

  // stage 1: stack data available, generation read issued
  logic                   s1_vld_r;
  kind_t                  s1_kind_r, kind_nxt;
  logic [IDX_FIELD_W-1:0] s1_idx_r, s1_idx_nxt;
  logic [IDX_FIELD_W-1:0] s1_res_idx;

  // stage 2: generation available, update written back
  logic                   s2_vld_r;
  kind_t                  s2_kind_r;
  logic [IDX_FIELD_W-1:0] s2_idx_r;
  logic [GEN_BITS-1:0]    gen_old;
  logic [GEN_BITS-1:0]    gen_new;
  logic                   gen_we;

  // result register
  logic     out_valid_r;
  out_rsp_t out_rsp_r, out_rsp_nxt;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- decode
  always_comb begin
    fc_nxt     = fc_r;
    nf_nxt     = nf_r;
    kind_nxt   = K_FULL;
    s1_idx_nxt = '0;
    push       = 1'b0;
    if (in_req.cmd == CMD_ALLOC) begin
      if (fc_r != '0) begin
        // reuse the most recently released index
        kind_nxt = K_POP;
        fc_nxt   = CW'(fc_r - CW'(1));
      end else if (nf_r != CW'(ENTRIES)) begin
        // first use of a never-allocated index
        kind_nxt   = K_FRESH;
        s1_idx_nxt = IDX_FIELD_W'(nf_r);
        nf_nxt     = CW'(nf_r + CW'(1));
      end else begin
        kind_nxt = K_FULL;
      end
    end else begin
      s1_idx_nxt = in_req.release_index;
      if (int'(in_req.release_index) < ENTRIES) begin
        kind_nxt = K_REL;
        // overflow only on a release of an index not held; push is dropped then
        if (fc_r != CW'(ENTRIES)) begin
          push   = 1'b1;
          fc_nxt = CW'(fc_r + CW'(1));
        end
      end else begin
        // index past the store: echoed, nothing changes
        kind_nxt = K_REL_OOB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= '0;
      nf_r     <= CW'(1);
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      if (accept) begin
        fc_r <= fc_nxt;
        nf_r <= nf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= kind_nxt;
      s1_idx_r  <= s1_idx_nxt;
    end
  end

  // free stack: push at the slot above the top, pop reads the top
  always_ff @(posedge clk) begin
    if (accept && push) begin
      stack_mem[AW'(fc_r)] <= in_req.release_index;
    end
    stack_q_r <= stack_mem[AW'(CW'(fc_r - CW'(1)))];
  end

  // ------------------------------------------------------- generation read
  assign s1_res_idx = (s1_kind_r == K_POP) ? stack_q_r : s1_idx_r;

  gha_gen_table #(
    .ENTRIES  (ENTRIES),
    .GEN_BITS (GEN_BITS)
  ) u_gen_table (
    .clk     (clk),
    .rd_addr (AW'(s1_res_idx)),
    .wr_en   (gen_we),
    .wr_addr (AW'(s2_idx_r)),
    .wr_data (gen_new),
    .rd_data (gen_old)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r <= s1_kind_r;
    s2_idx_r  <= s1_res_idx;
  end

  // ------------------------------------------------------ update and result
  always_comb begin
    gen_new                = GEN_BITS'(1);
    gen_we                 = 1'b0;
    out_rsp_nxt.index      = s2_idx_r;
    out_rsp_nxt.generation = '0;
    out_rsp_nxt.status     = ST_ALLOCATED;
    case (s2_kind_r)
      K_POP: begin
        out_rsp_nxt.generation = GEN_FIELD_W'(gen_old);
      end
      K_FRESH: begin
        gen_new                = GEN_BITS'(1);
        gen_we                 = s2_vld_r;
        out_rsp_nxt.generation = GEN_FIELD_W'(1);
      end
      K_REL: begin
        // wrap skips generation zero
        gen_new                = (gen_old == GEN_MAX) ? GEN_BITS'(1)
                                                      : GEN_BITS'(gen_old + GEN_BITS'(1));
        gen_we                 = s2_vld_r;
        out_rsp_nxt.generation = GEN_FIELD_W'(gen_new);
        out_rsp_nxt.status     = ST_RELEASED;
      end
      K_REL_OOB: begin
        out_rsp_nxt.status = ST_RELEASED;
      end
      default: begin
        // full: nothing handed out
        out_rsp_nxt.index  = '0;
        out_rsp_nxt.status = ST_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ------------------------------------------------------------ assertions
  // every transfer yields exactly one result, after the stack read, generation read and update registers
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == $past(accept, 3))
    else $error("result strobe out of step with request transfers");

  // counters stay within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fc_r <= CW'(ENTRIES)) && (nf_r >= CW'(1)) && (nf_r <= CW'(ENTRIES)))
    else $error("free count or fresh index out of range");

  // fresh index only moves forward, one step per transfer
  a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (nf_r == $past(nf_r)) || (nf_r == CW'($past(nf_r) + CW'(1))))
    else $error("fresh index moved by more than one");

  // a pop lowers the free count by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.cmd == CMD_ALLOC) && (fc_r != '0)) |=> (fc_r == $past(fc_r) - CW'(1)))
    else $error("pop did not lower the free count");

endmodule

// File: src/gha_gen_table.sv
// ----------------------------------------------------------------------------
// gha_gen_table
// generation store: one write port, one registered read port, with bypass of
// the write that lands on the same edge as the read
// ----------------------------------------------------------------------------
module gha_gen_table #(
  parameter int ENTRIES  = 1024,
  parameter int GEN_BITS = 32
) (
  input  logic                       clk,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [GEN_BITS-1:0]        wr_data,
  output logic [GEN_BITS-1:0]        rd_data
);

  logic [GEN_BITS-1:0] mem [ENTRIES];
  logic [GEN_BITS-1:0] rd_q_r;
  logic [GEN_BITS-1:0] fwd_q_r;
  logic                fwd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r    <= mem[rd_addr];
    fwd_q_r   <= wr_data;
    fwd_hit_r <= wr_en && (wr_addr == rd_addr);
  end

  // read sees the write retired on the same edge
  assign rd_data = fwd_hit_r ? fwd_q_r : rd_q_r;

endmodule
